// ----- rtl/i2c_display_write_serializer_macros.svh -----
// Assertion macros used by the serializer's top-level RTL file.
`ifndef I2C_DISPLAY_WRITE_SERIALIZER_MACROS_SVH
`define I2C_DISPLAY_WRITE_SERIALIZER_MACROS_SVH

// Checked on every rising edge of aclk while reset is released.
`define I2CDWS_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, during reset as well.
`define I2CDWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/i2cdws_pkg.sv -----
// Types and constants shared by the I2C display write serializer.
`default_nettype none
package i2cdws_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BYTES_PER_TXN = 3;
    localparam int WORD_W        = BITS_PER_BYTE * BYTES_PER_TXN;

    localparam logic [7:0] ADDR_RESET   = 8'h78;
    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BIT   = 2'd1,
        KIND_ACK   = 2'd2,
        KIND_STOP  = 2'd3
    } sym_kind_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_START,
        BS_BIT,
        BS_ACK,
        BS_STOP
    } back_state_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

endpackage
`default_nettype wire

// ----- rtl/i2c_display_write_serializer.sv -----
// Top level of the I2C display write serializer: address register, front, queue, back.
`default_nettype none
// Turns each display-controller byte into one complete I2C write transaction of
// 29 bus symbols: a start, the address byte, the control byte (0x00 when the
// input is a command, 0x40 when it is display data) and the payload byte, each
// byte sent most significant bit first and followed by an acknowledge slot in
// which SDA is released high, and finally a stop that carries tlast. The block
// streams one symbol per clock cycle while m_tready is high; the serializer in
// the back end offers one symbol per cycle when its output register is free
// and moves from the stop of one transaction straight to the start of the
// next when another word waits in the queue. A holding register and a queue of
// QUEUE_DEPTH entries (two by default) sit in front of the serializer, so new
// input transactions are accepted while earlier ones are still being shifted
// out or while the output is stalled. An accepted input passes through the
// holding register, the queue and the back end's start state into the output
// register. The device address comes from the address register, which resets
// to 0x78 and should only be written while no transaction is in flight.
module i2c_display_write_serializer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // Address register write port.
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    // Input channel.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] payload
    input  wire logic       s_tuser,   // [0] is_data
    // Bus symbol channel.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [0] sda_level, [7:1] zero
    output logic [1:0]      m_tuser,   // [1:0] symbol_kind
    output logic            m_tlast    // last symbol (stop) of the transaction
);

`include "i2c_display_write_serializer_macros.svh"

    // The address byte register; apart from reset it only changes on a configuration write.
    logic [7:0] address_reg, address_next;

    assign address_next = cfg_wr_en ? cfg_wr_data : address_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg <= i2cdws_pkg::ADDR_RESET;
        end else begin
            address_reg <= address_next;
        end
    end

    // Interconnect between the front end, the queue and the serializer.
    i2cdws_pkg::queue_stat_t       q_stat;
    logic                          q_push;
    logic                          q_pop;
    logic [i2cdws_pkg::WORD_W-1:0] q_wdata;
    logic [i2cdws_pkg::WORD_W-1:0] q_rdata;

    // The front end composes {address, control, payload} for each transaction.
    i2cdws_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .address_byte (address_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .q_stat       (q_stat),
        .q_push       (q_push),
        .q_wdata      (q_wdata)
    );

    // The queue decouples input acceptance from symbol generation.
    i2cdws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // The back end walks each word out as 29 symbols through its output register.
    i2cdws_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The front end never pushes into a full queue.
    `I2CDWS_ASSERT_RUN(a_no_push_full, (q_push |-> !q_stat.full), "push into full queue")
    // The serializer never pops an empty queue.
    `I2CDWS_ASSERT_RUN(a_no_pop_empty, (q_pop |-> !q_stat.empty), "pop from empty queue")
    // Only the stop symbol closes a transaction.
    `I2CDWS_ASSERT_RUN(a_last_is_stop,
        (m_tvalid && m_tlast |-> m_tuser == i2cdws_pkg::KIND_STOP), "tlast on non-stop symbol")
    // A symbol that directly follows a delivered stop must open a new transaction.
    `I2CDWS_ASSERT_RUN(a_start_after_stop,
        (m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tuser == i2cdws_pkg::KIND_START),
        "transaction not opened by start")

endmodule
`default_nettype wire

// ----- rtl/i2cdws_front.sv -----
// Front end: accepts input transactions and builds the three-byte bus word.
`default_nettype none
module i2cdws_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [7:0]                    address_byte,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tuser,
    input  wire i2cdws_pkg::queue_stat_t       q_stat,
    output logic                               q_push,
    output logic [i2cdws_pkg::WORD_W-1:0]      q_wdata
);

    logic                          hold_valid_reg, hold_valid_next;
    logic [i2cdws_pkg::WORD_W-1:0] hold_word_reg, hold_word_next;
    logic                          accept;
    logic [7:0]                    ctrl_byte;

    // The holding stage drains into the queue whenever the queue has room.
    assign q_push   = hold_valid_reg && !q_stat.full;
    assign q_wdata  = hold_word_reg;
    assign s_tready = !hold_valid_reg || !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    assign ctrl_byte = s_tuser ? i2cdws_pkg::CTRL_DATA : i2cdws_pkg::CTRL_COMMAND;

    always_comb begin
        hold_valid_next = hold_valid_reg && !q_push;
        hold_word_next  = hold_word_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
            hold_word_next  = {address_byte, ctrl_byte, s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_word_reg <= hold_word_next;
    end

endmodule
`default_nettype wire

// ----- rtl/i2cdws_queue.sv -----
// Short FIFO of bus words between the front end and the serializer.
`default_nettype none
module i2cdws_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire logic [i2cdws_pkg::WORD_W-1:0] wdata,
    input  wire logic                          pop,
    output logic [i2cdws_pkg::WORD_W-1:0]      rdata,
    output i2cdws_pkg::queue_stat_t            stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [i2cdws_pkg::WORD_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]              wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]              rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]              count_reg, count_next;

    assign rdata      = entry_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/i2cdws_back.sv -----
// Back end: serializes one bus word into start, bits, acknowledges and stop.
`default_nettype none
module i2cdws_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire i2cdws_pkg::queue_stat_t       q_stat,
    input  wire logic [i2cdws_pkg::WORD_W-1:0] q_rdata,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast
);

    localparam logic [2:0] LAST_BIT  = 3'(i2cdws_pkg::BITS_PER_BYTE - 1);
    localparam logic [1:0] LAST_BYTE = 2'(i2cdws_pkg::BYTES_PER_TXN - 1);

    i2cdws_pkg::back_state_t       state_reg, state_next;
    logic [i2cdws_pkg::WORD_W-1:0] shift_reg, shift_next;
    logic [2:0]                    bit_cnt_reg, bit_cnt_next;
    logic [1:0]                    byte_cnt_reg, byte_cnt_next;

    logic                          out_valid_reg, out_valid_next;
    i2cdws_pkg::sym_kind_t         out_kind_reg, out_kind_next;
    logic                          out_sda_reg, out_sda_next;
    logic                          out_last_reg, out_last_next;

    logic                          out_free;
    logic                          emit;
    i2cdws_pkg::sym_kind_t         emit_kind;
    logic                          emit_sda;
    logic                          emit_last;

    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            i2cdws_pkg::BS_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = i2cdws_pkg::BS_START;
                end
            end
            i2cdws_pkg::BS_START: begin
                if (out_free) begin
                    state_next = i2cdws_pkg::BS_BIT;
                end
            end
            i2cdws_pkg::BS_BIT: begin
                if (out_free && bit_cnt_reg == LAST_BIT) begin
                    state_next = i2cdws_pkg::BS_ACK;
                end
            end
            i2cdws_pkg::BS_ACK: begin
                if (out_free) begin
                    state_next = (byte_cnt_reg == LAST_BYTE) ? i2cdws_pkg::BS_STOP
                                                             : i2cdws_pkg::BS_BIT;
                end
            end
            i2cdws_pkg::BS_STOP: begin
                if (out_free) begin
                    state_next = q_stat.empty ? i2cdws_pkg::BS_IDLE : i2cdws_pkg::BS_START;
                end
            end
            default: begin
                state_next = i2cdws_pkg::BS_IDLE;
            end
        endcase
    end

    // Outputs of the state machine: the symbol on offer and the queue pop.
    always_comb begin
        emit      = 1'b0;
        emit_kind = i2cdws_pkg::KIND_START;
        emit_sda  = 1'b0;
        emit_last = 1'b0;
        q_pop     = 1'b0;
        case (state_reg)
            i2cdws_pkg::BS_IDLE: begin
                q_pop = !q_stat.empty;
            end
            i2cdws_pkg::BS_START: begin
                emit = 1'b1;
            end
            i2cdws_pkg::BS_BIT: begin
                emit      = 1'b1;
                emit_kind = i2cdws_pkg::KIND_BIT;
                emit_sda  = shift_reg[i2cdws_pkg::WORD_W-1];
            end
            i2cdws_pkg::BS_ACK: begin
                emit      = 1'b1;
                emit_kind = i2cdws_pkg::KIND_ACK;
                emit_sda  = 1'b1;
            end
            i2cdws_pkg::BS_STOP: begin
                emit      = 1'b1;
                emit_kind = i2cdws_pkg::KIND_STOP;
                emit_last = 1'b1;
                q_pop     = out_free && !q_stat.empty;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Shift register, counters and the output register.
    always_comb begin
        shift_next     = shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_sda_next   = out_sda_reg;
        out_last_next  = out_last_reg;

        if (q_pop) begin
            shift_next    = q_rdata;
            bit_cnt_next  = '0;
            byte_cnt_next = '0;
        end else if (out_free && state_reg == i2cdws_pkg::BS_BIT) begin
            shift_next   = {shift_reg[i2cdws_pkg::WORD_W-2:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 1'b1;
        end else if (out_free && state_reg == i2cdws_pkg::BS_ACK) begin
            bit_cnt_next  = '0;
            byte_cnt_next = byte_cnt_reg + 1'b1;
        end

        if (out_free && emit) begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_sda_next   = emit_sda;
            out_last_next  = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= i2cdws_pkg::BS_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        shift_reg    <= shift_next;
        bit_cnt_reg  <= bit_cnt_next;
        byte_cnt_reg <= byte_cnt_next;
        out_kind_reg <= out_kind_next;
        out_sda_reg  <= out_sda_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_sda_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
